// ===== rtl/positional_list_engine_core_defines.svh =====
// Assertion macros used by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define PLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define PLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

// ===== rtl/ple_pkg.sv =====
// Package with command, status and cell control definitions for the list engine.
`timescale 1ns / 1ps

package ple_pkg;

  // Request command codes.
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_PUSH   = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;
  localparam logic [2:0] CMD_INSERT = 3'd5;
  localparam logic [2:0] CMD_DELETE = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Cell update operations.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tgt;
    logic [7:0]  count;
    logic [31:0] item;
  } cell_ctrl_t;

endpackage

// ===== rtl/positional_list_engine_core.sv =====
// Top level of the list engine: command sequencer, cell chain and result register.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit values, positions counted from 1.
// Input channel (in_valid/in_ready): one request with in_cmd, in_pos, in_item.
// Result channel (out_valid/out_ready): one result per request with out_status,
// out_value_out, out_found_pos and out_length (element count after the request).
// Each request passes three steps: accept, a compare cycle in which every cell
// checks its element against the item, and a resolve cycle that reduces the cell
// hits and reads over the chain and shifts the cells for insert or delete.
// A new request is taken only once the previous one has resolved and the
// sequencer is back in idle. A result appears on out_valid from the result
// register after its request has passed the compare and resolve states.
// in_ready is high while no request is in progress, also while a result waits.
// If the receiver stalls, the resolve cycle holds until the result register is
// free, so no result is lost or overwritten.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// element contents are not cleared, and are only read below the count.
`include "positional_list_engine_core_defines.svh"

module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [7:0]         in_pos,
  input  logic signed [31:0] in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_out,
  output logic [7:0]         out_found_pos,
  output logic [7:0]         out_length
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    cmd_r;
  logic [7:0]    pos_r;
  logic [31:0]   item_r;

  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   value_r, value_nxt;
  logic [7:0]    found_r, found_nxt;
  logic [7:0]    length_r;

  logic          out_free;
  logic          resolve;
  cell_ctrl_t    ctrl;
  logic [1:0]    op_nxt;
  logic [7:0]    tgt_nxt;

  logic [31:0]    elem   [DEPTH];
  logic [31:0]    rd_val [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] low_hit;
  logic [IW-1:0]  hit_idx;
  logic [31:0]    rd_or;
  logic [8:0]     cnt9;
  logic [8:0]     pos9;

  assign out_free = !out_valid_r || out_ready;
  assign resolve  = (state_r == S_RES) && out_free;
  assign in_ready = (state_r == S_IDLE);
  assign cnt9     = 9'(count_r);
  assign pos9     = {1'b0, pos_r};

  // Sequencer: idle, compare, resolve.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RES;
      S_RES:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      pos_r  <= in_pos;
      item_r <= in_item;
    end
  end

  // Cell chain.
  assign ctrl.op    = resolve ? op_nxt : OP_HOLD;
  assign ctrl.tgt   = tgt_nxt;
  assign ctrl.count = 8'(count_r);
  assign ctrl.item  = item_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [31:0] left_v;
    logic [31:0] right_v;
    if (k == 0) begin : g_first
      assign left_v = item_r;
    end else begin : g_mid_l
      assign left_v = elem[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_v = elem[k];
    end else begin : g_mid_r
      assign right_v = elem[k+1];
    end
    ple_cell #(.IDX(k)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_v),
      .right_val (right_v),
      .elem      (elem[k]),
      .hit       (hits[k]),
      .rd_val    (rd_val[k])
    );
  end

  // Reduce the cell reads and isolate the first hit of the chain.
  always_comb begin
    rd_or   = '0;
    hit_idx = '0;
    low_hit = hits & (~hits + 1'b1);
    for (int k = 0; k < DEPTH; k++) begin
      rd_or = rd_or | rd_val[k];
      if (low_hit[k]) begin
        hit_idx = hit_idx | IW'(k);
      end
    end
  end

  // Resolve the request against the count and the reduced cell data.
  always_comb begin
    status_nxt = ST_OK;
    value_nxt  = '0;
    found_nxt  = '0;
    count_nxt  = count_r;
    op_nxt     = OP_HOLD;
    tgt_nxt    = pos_r - 8'd1;
    unique case (cmd_r)
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      CMD_PUSH, CMD_APPEND: begin
        tgt_nxt = (cmd_r == CMD_PUSH) ? 8'd0 : 8'(count_r);
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt    = OP_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_GET: begin
        if (pos_r == 8'd0) begin
          value_nxt = '0;
        end else if (pos9 > cnt9) begin
          status_nxt = ST_BADPOS;
        end else begin
          value_nxt = rd_or;
        end
      end
      CMD_FIND: begin
        if (hits == '0) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          found_nxt = 8'(hit_idx) + 8'd1;
        end
      end
      CMD_INSERT: begin
        if (pos_r == 8'd0 || pos9 > cnt9 + 9'd1) begin
          status_nxt = ST_BADPOS;
        end else if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt    = OP_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_r == 8'd0 || pos9 > cnt9) begin
          status_nxt = ST_BADPOS;
        end else begin
          op_nxt    = OP_DEL;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (resolve) begin
      count_r <= count_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resolve) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      found_r  <= found_nxt;
      length_r <= 8'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_found_pos = found_r;
  assign out_length    = length_r;

  // The count never passes the capacity.
  `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FULL_CNT)
  // A full status is only reported with a full list.
  `PLE_ASSERT_IMP(a_full_len, out_valid && out_status == ST_FULL, out_length == 8'(DEPTH))
  // A found position is a live position and comes with an ok status.
  `PLE_ASSERT_IMP(a_found_ok, out_valid && out_found_pos != 8'd0,
                  out_status == ST_OK && out_found_pos <= out_length)
  // An accepted request always moves on to the compare cycle.
  `PLE_ASSERT_NXT(a_acc_cmp, in_valid && in_ready, state_r == S_CMP)

endmodule

// ===== rtl/ple_cell.sv =====
// One storage cell of the list: holds an element, shifts with its neighbors, compares.
`timescale 1ns / 1ps

module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] left_val,
  input  logic [31:0] right_val,
  output logic [31:0] elem,
  output logic        hit,
  output logic [31:0] rd_val
);

  localparam logic [7:0] IDX8 = 8'(IDX);

  logic [31:0] elem_r;
  logic        hit_r;

  // Shift in from the left neighbor on insert, from the right one on delete.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INS: begin
        if (IDX8 > ctrl.tgt) begin
          elem_r <= left_val;
        end else if (IDX8 == ctrl.tgt) begin
          elem_r <= ctrl.item;
        end
      end
      OP_DEL: begin
        if (IDX8 >= ctrl.tgt) begin
          elem_r <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

  // A hit needs a live entry holding the searched value.
  always_ff @(posedge clk) begin
    hit_r <= (elem_r == ctrl.item) && (IDX8 < ctrl.count);
  end

  // Only the addressed cell drives its element onto the read tree.
  assign rd_val = (IDX8 == ctrl.tgt) ? elem_r : 32'd0;
  assign elem   = elem_r;
  assign hit    = hit_r;

endmodule

// ===== verif/tb_positional_list_engine_core.sv =====
// Self-checking testbench for the positional list engine core with a built-in list predictor.
`timescale 1ns / 1ps

module tb_positional_list_engine_core
  import ple_pkg::*;
;

  localparam int LIST_DEPTH = 64;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 400;
  localparam int POOL_SIZE = 12;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 8;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} gen_mode_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [7:0]  found_pos;
    logic [7:0]  length;
  } list_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  pos;
    logic [31:0] item;
    bit          drain;
  } list_req_t;

  typedef struct {
    logic [2:0]   cmd;
    list_result_t want;
  } list_expect_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_cmd = CMD_CLEAR;
  logic [7:0]         in_pos = '0;
  logic signed [31:0] in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_value_out;
  logic [7:0]         out_found_pos;
  logic [7:0]         out_length;

  // Predicted list contents and fill level.
  logic [31:0] list_vals [LIST_DEPTH];
  int          list_len = 0;

  list_req_t    pending_reqs[$];
  list_expect_t expected_results[$];

  // Generator-side view of the fill level, used only to aim positions.
  int          gen_len = 0;
  logic [31:0] item_pool [POOL_SIZE];

  int send_gap = 0;
  int recv_stall = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int fail_count = 0;
  int idle_cycles = 0;

  positional_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_pos       (in_pos),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .out_found_pos(out_found_pos),
    .out_length   (out_length)
  );

  always #2 clk = ~clk;

  // Shift the tail up by one and store a value at index idx.
  function automatic void open_slot(int idx, logic [31:0] v);
    for (int k = list_len; k > idx; k--) begin
      list_vals[k] = list_vals[k - 1];
    end
    list_vals[idx] = v;
    list_len++;
  endfunction

  // Apply one request to the predicted list and return the result it should produce.
  function automatic list_result_t apply_list_cmd(logic [2:0] cmd, logic [7:0] pos,
                                                  logic [31:0] item);
    list_result_t r;
    r = '0;
    case (cmd) inside
      CMD_CLEAR: begin
        list_len = 0;
      end
      CMD_PUSH, CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          open_slot((cmd == CMD_PUSH) ? 0 : list_len, item);
        end
      end
      CMD_GET: begin
        if (pos != 0) begin
          if (int'(pos) > list_len) begin
            r.status = ST_BADPOS;
          end else begin
            r.value_out = list_vals[int'(pos) - 1];
          end
        end
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (list_vals[k] == item) begin
            r.found_pos = 8'(k + 1);
            r.status = ST_OK;
            break;
          end
        end
      end
      CMD_INSERT: begin
        // Position is checked before fullness.
        if (pos == 0 || int'(pos) > list_len + 1) begin
          r.status = ST_BADPOS;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          open_slot(int'(pos) - 1, item);
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || int'(pos) > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int k = int'(pos) - 1; k + 1 < list_len; k++) begin
            list_vals[k] = list_vals[k + 1];
          end
          list_len--;
        end
      end
      default: begin
      end
    endcase
    r.length = 8'(list_len);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Queue one request and track how it changes the fill level.
  task automatic add_req(input logic [2:0] cmd, input logic [7:0] pos,
                         input logic [31:0] item, input bit drain);
    list_req_t req;
    req.cmd = cmd;
    req.pos = pos;
    req.item = item;
    req.drain = drain;
    pending_reqs.push_back(req);
    case (cmd) inside
      CMD_CLEAR: gen_len = 0;
      CMD_PUSH, CMD_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      CMD_INSERT: begin
        if (pos >= 1 && int'(pos) <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
      end
      CMD_DELETE: if (pos >= 1 && int'(pos) <= gen_len) gen_len--;
      default: begin
      end
    endcase
  endtask

  // Values mostly come from a small pool so that searches hit often.
  function automatic logic [31:0] pick_item();
    if ($urandom_range(0, 99) < 60) return item_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Positions are mostly legal, with zero, just past the end and anything at all mixed in.
  function automatic logic [7:0] pick_pos(logic [2:0] cmd);
    int hi;
    int r;
    hi = (cmd == CMD_INSERT) ? gen_len + 1 : gen_len;
    r = $urandom_range(0, 99);
    if (r < 75 && hi >= 1) return 8'($urandom_range(1, hi));
    if (r < 85) return 8'd0;
    if (r < 95) return 8'(hi + 1);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_cmd(gen_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 35) return CMD_PUSH;
        if (r < 65) return CMD_APPEND;
        if (r < 88) return CMD_INSERT;
        if (r < 92) return CMD_GET;
        if (r < 96) return CMD_FIND;
        return CMD_DELETE;
      end
      MODE_SHRINK: begin
        if (r < 60) return CMD_DELETE;
        if (r < 75) return CMD_GET;
        if (r < 90) return CMD_FIND;
        return CMD_APPEND;
      end
      default: begin
        if (r < 3) return CMD_CLEAR;
        if (r < 6) return CMD_UNUSED;
        return 3'($urandom_range(1, 6));
      end
    endcase
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int        k;
    int        seg_len;
    int        n_random;
    bit        first_seg;
    bit        hold;
    int        r;
    gen_mode_t mode;
    logic [2:0] cmd;

    item_pool[0] = 32'h0000_0000;
    item_pool[1] = 32'hFFFF_FFFF;
    item_pool[2] = 32'h7FFF_FFFF;
    item_pool[3] = 32'h8000_0000;
    for (k = 4; k < POOL_SIZE; k++) item_pool[k] = $urandom();

    // Directed requests: empty-list corners, extremes and the bad-position and not-found paths.
    add_req(CMD_GET,    8'd0,   32'h0000_0000, 1'b0);
    add_req(CMD_GET,    8'd1,   32'h0000_0000, 1'b0);
    add_req(CMD_DELETE, 8'd0,   32'h0000_0000, 1'b0);
    add_req(CMD_DELETE, 8'd1,   32'h0000_0000, 1'b0);
    add_req(CMD_FIND,   8'd0,   32'h0000_0005, 1'b0);
    add_req(CMD_INSERT, 8'd0,   32'h1111_1111, 1'b0);
    add_req(CMD_INSERT, 8'd2,   32'h1111_1111, 1'b0);
    add_req(CMD_INSERT, 8'd1,   32'h7FFF_FFFF, 1'b0);
    add_req(CMD_PUSH,   8'd0,   32'h8000_0000, 1'b0);
    add_req(CMD_APPEND, 8'd255, 32'h0000_0000, 1'b0);
    add_req(CMD_APPEND, 8'd0,   32'hFFFF_FFFF, 1'b0);
    add_req(CMD_INSERT, 8'd5,   32'h5555_AAAA, 1'b0);
    add_req(CMD_INSERT, 8'd7,   32'hAAAA_5555, 1'b0);
    add_req(CMD_GET,    8'd1,   32'h0000_0000, 1'b0);
    add_req(CMD_GET,    8'd5,   32'hFFFF_FFFF, 1'b0);
    add_req(CMD_GET,    8'd255, 32'h0000_0000, 1'b0);
    add_req(CMD_FIND,   8'd0,   32'hFFFF_FFFF, 1'b0);
    add_req(CMD_FIND,   8'd0,   32'h1234_5678, 1'b0);
    add_req(CMD_DELETE, 8'd6,   32'h0000_0000, 1'b0);
    add_req(CMD_DELETE, 8'd5,   32'h0000_0000, 1'b0);
    add_req(CMD_DELETE, 8'd1,   32'h0000_0000, 1'b0);
    add_req(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF, 1'b0);
    add_req(CMD_CLEAR,  8'd255, 32'hFFFF_FFFF, 1'b0);
    add_req(CMD_GET,    8'd1,   32'h0000_0000, 1'b0);

    // Random segments; the first one fills the list well past full.
    n_random = 0;
    first_seg = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (first_seg) mode = MODE_GROW;
      else if (r < 40) mode = MODE_GROW;
      else if (r < 65) mode = MODE_SHRINK;
      else mode = MODE_MIXED;
      seg_len = first_seg ? 100 : $urandom_range(20, 60);
      hold = first_seg || ($urandom_range(0, 99) < 30);
      for (k = 0; k < seg_len; k++) begin
        cmd = pick_cmd(mode);
        add_req(cmd, pick_pos(cmd), pick_item(), hold && k == 0);
        if (cmd != CMD_UNUSED) n_random++;
      end
      first_seg = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled.
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS positional_list_engine_core");
    end else begin
      $display("FAIL positional_list_engine_core");
    end
    $finish;
  end

  // Request driver: predicts each accepted request, then presents the next one after a random gap, possibly none.
  always @(posedge clk) begin
    list_req_t    req;
    list_expect_t ent;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ent.cmd = in_cmd;
        ent.want = apply_list_cmd(in_cmd, in_pos, in_item);
        expected_results.push_back(ent);
        send_gap = send_quiet ? 0 : idle_len();
        if ($urandom_range(0, 99) < 4) send_quiet = !send_quiet;
      end
      // A request not yet taken stays on the port unchanged.
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_results.size() != 0)) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_cmd <= req.cmd;
          in_pos <= req.pos;
          in_item <= req.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result with the oldest prediction and stalls at random.
  always @(posedge clk) begin
    list_expect_t ent;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result: status=%0d value=%0d pos=%0d len=%0d",
                     out_status, out_value_out, out_found_pos, out_length);
          end
        end else begin
          ent = expected_results.pop_front();
          if (out_status !== ent.want.status || out_value_out !== ent.want.value_out ||
              out_found_pos !== ent.want.found_pos || out_length !== ent.want.length) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch cmd=%0d: expected status=%0d value=%0d pos=%0d len=%0d",
                       ent.cmd, ent.want.status, $signed(ent.want.value_out),
                       ent.want.found_pos, ent.want.length);
              $display("                 actual   status=%0d value=%0d pos=%0d len=%0d",
                       out_status, out_value_out, out_found_pos, out_length);
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 99) < 15) recv_stall = idle_len();
      end
      if ($urandom_range(0, 99) == 0) recv_quiet = !recv_quiet;
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
          $display("FAIL positional_list_engine_core");
          $finish;
        end
      end
    end
  end

endmodule
